// ----- rtl/circle_obb_slide_collision_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the circle and oriented box collision block
// Shared property forms with the block's clock and reset.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_OBB_SLIDE_COLLISION_ASSERT_SVH
`define CIRCLE_OBB_SLIDE_COLLISION_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define COBB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cobb: assertion failed");

// Consequent holds in the cycle after the antecedent.
`define COBB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cobb: assertion failed");

`endif

// ----- rtl/cobb_pkg.sv -----
// ----------------------------------------------------------------------------
// cobb_pkg
// Types, codes and constants shared by the collision block's modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cobb_pkg;

  localparam int MAX_BOXES_DEF   = 16;
  localparam int MAX_CIRCLES_DEF = 16;
  localparam int MAX_STEPS_DEF   = 64;
  localparam int N_W             = 11;
  localparam int CORDIC_ITERS    = 14;

  localparam logic [29:0]        MIN_STEP = 30'd3277;
  localparam logic signed [17:0] HALF_PI  = 18'sd12868;
  localparam logic signed [17:0] PI_Q13   = 18'sd25736;
  localparam logic signed [17:0] GAIN     = 18'sd9949;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_BOX    = 2'd1;
  localparam logic [1:0] FUNC_CIRCLE = 2'd2;
  localparam logic [1:0] FUNC_MOVE   = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam logic [2:0] REG_RADIUS = 3'd0;
  localparam logic [2:0] REG_BOUNDS = 3'd1;
  localparam logic [2:0] REG_MIN_X  = 3'd2;
  localparam logic [2:0] REG_MAX_X  = 3'd3;
  localparam logic [2:0] REG_MIN_Z  = 3'd4;
  localparam logic [2:0] REG_MAX_Z  = 3'd5;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_z;
    logic signed [31:0] delta_x;
    logic signed [31:0] delta_z;
    logic signed [31:0] center_x;
    logic signed [31:0] center_z;
    logic [30:0]        half_x;
    logic [30:0]        half_z;
    logic signed [15:0] angle;
    logic [30:0]        circle_radius_in;
  } item_t;

  typedef struct packed {
    logic signed [31:0] new_x;
    logic signed [31:0] new_z;
    logic [1:0]         status;
  } result_t;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cz;
    logic [30:0]        hx;
    logic [30:0]        hz;
    logic signed [15:0] cs;
    logic signed [15:0] sn;
  } box_t;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cz;
    logic [30:0]        r;
  } circ_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CINIT, OP_CSTEP, OP_DISTX, OP_DISTZ, OP_KINIT, OP_KSQ, OP_KNEXT,
    OP_DINIT, OP_DSTEP, OP_DFIX, OP_TESTX, OP_TESTZ, OP_BREL, OP_BM0, OP_BM1,
    OP_BM2, OP_BM3, OP_BCLAMP, OP_CREL, OP_SQA, OP_SQB, OP_SQR, OP_COMMIT,
    OP_FINZ, OP_FINM
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [3:0]       iter;
    logic [N_W-1:0]   n;
  } dp_cmd_t;

  typedef struct packed {
    logic stop;
    logic hit;
  } dp_stat_t;

  function automatic logic signed [17:0] atan_q13(input logic [3:0] i);
    logic signed [17:0] v;
    case (i)
      4'd0:    v = 18'sd6434;
      4'd1:    v = 18'sd3798;
      4'd2:    v = 18'sd2007;
      4'd3:    v = 18'sd1019;
      4'd4:    v = 18'sd511;
      4'd5:    v = 18'sd256;
      4'd6:    v = 18'sd128;
      4'd7:    v = 18'sd64;
      4'd8:    v = 18'sd32;
      4'd9:    v = 18'sd16;
      4'd10:   v = 18'sd8;
      4'd11:   v = 18'sd4;
      4'd12:   v = 18'sd2;
      4'd13:   v = 18'sd1;
      default: v = 18'sd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/cobb_ram.sv -----
// ----------------------------------------------------------------------------
// cobb_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cobb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH > 1 ? DEPTH : 2)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/cobb_dp.sv -----
// ----------------------------------------------------------------------------
// cobb_dp
// Datapath: configuration registers, CORDIC, step search, divider,
// collider distance tests and final clamping.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cobb_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  cobb_pkg::item_t     item,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  cobb_pkg::dp_cmd_t   cmd,
  input  cobb_pkg::box_t      box_rd,
  input  cobb_pkg::circ_t     circ_rd,
  output cobb_pkg::box_t      box_wr,
  output cobb_pkg::circ_t     circ_wr,
  output cobb_pkg::dp_stat_t  stat,
  output logic signed [31:0]  new_x,
  output logic signed [31:0]  new_z
);

  localparam int N_W_L = cobb_pkg::N_W;

  logic [30:0]        pr;
  logic               bnd;
  logic signed [31:0] rmin_x, rmax_x, rmin_z, rmax_z;
  cobb_pkg::item_t    it;

  logic signed [17:0] cx_r, cy_r, cz_r;
  logic               cneg;
  logic signed [17:0] ang, fold_z, fx, fy;
  logic               fold_neg;

  logic [64:0]        dist2;
  logic [41:0]        m;
  logic [65:0]        msq;
  logic [29:0]        step;

  logic [31:0]        qx, qz;
  logic [N_W_L-1:0]   remx, remz;
  logic [N_W_L:0]     r2x, r2z;
  logic               gex, gez;
  logic signed [32:0] sdx, sdz;

  logic signed [34:0] px, pz, tx, tz;
  logic signed [35:0] rx, rz;
  logic signed [51:0] acc_x, acc_z;
  logic signed [15:0] ma;
  logic signed [35:0] mb;
  logic signed [51:0] mp;

  logic [32:0]        sq_a;
  logic [65:0]        sq_p;
  logic [65:0]        sqacc, rsq;
  logic [66:0]        sqsum;
  logic [32:0]        rr;
  logic [31:0]        ex, ez;
  logic               far;

  logic signed [51:0] lx, lz, hx_s, hz_s, cl_x, cl_z, ddx, ddz;
  logic [51:0]        adx, adz;
  logic signed [35:0] dcx, dcz;
  logic [35:0]        acx, acz;
  logic signed [34:0] fin_x, fin_z;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic signed [15:0] clamp16(input logic signed [17:0] v);
    logic signed [17:0] c;
    c = v;
    if (c < -18'sd16384) c = -18'sd16384;
    if (c > 18'sd16384) c = 18'sd16384;
    return c[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [34:0] c;
    c = v;
    if (c < -35'sd2147483648) c = -35'sd2147483648;
    if (c > 35'sd2147483647) c = 35'sd2147483647;
    return c[31:0];
  endfunction

  function automatic logic signed [34:0] sx35(input logic signed [31:0] v);
    return {{3{v[31]}}, v};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      pr     <= 31'd32768;
      bnd    <= 1'b0;
      rmin_x <= '0;
      rmax_x <= '0;
      rmin_z <= '0;
      rmax_z <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cobb_pkg::REG_RADIUS: pr     <= cfg_data[30:0];
        cobb_pkg::REG_BOUNDS: bnd    <= cfg_data[0];
        cobb_pkg::REG_MIN_X:  rmin_x <= cfg_data;
        cobb_pkg::REG_MAX_X:  rmax_x <= cfg_data;
        cobb_pkg::REG_MIN_Z:  rmin_z <= cfg_data;
        cobb_pkg::REG_MAX_Z:  rmax_z <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    ang      = {{2{it.angle[15]}}, it.angle};
    fold_z   = ang;
    fold_neg = 1'b0;
    if (ang > cobb_pkg::HALF_PI) begin
      fold_z   = ang - cobb_pkg::PI_Q13;
      fold_neg = 1'b1;
    end else if (ang < -cobb_pkg::HALF_PI) begin
      fold_z   = ang + cobb_pkg::PI_Q13;
      fold_neg = 1'b1;
    end
    fx = cneg ? -cx_r : cx_r;
    fy = cneg ? -cy_r : cy_r;
  end

  assign box_wr = '{cx: it.center_x, cz: it.center_z, hx: it.half_x, hz: it.half_z,
                    cs: clamp16(fx), sn: clamp16(fy)};
  assign circ_wr = '{cx: it.center_x, cz: it.center_z, r: it.circle_radius_in};

  assign step = (pr[30:1] < cobb_pkg::MIN_STEP) ? cobb_pkg::MIN_STEP : pr[30:1];

  always_comb begin
    r2x = {remx, qx[31]};
    r2z = {remz, qz[31]};
    gex = r2x >= {1'b0, cmd.n};
    gez = r2z >= {1'b0, cmd.n};
  end

  always_comb begin
    case (cmd.op)
      cobb_pkg::OP_DISTX: sq_a = {1'b0, mag32(it.delta_x)};
      cobb_pkg::OP_DISTZ: sq_a = {1'b0, mag32(it.delta_z)};
      cobb_pkg::OP_KSQ:   sq_a = {1'b0, m[31:0]};
      cobb_pkg::OP_SQA:   sq_a = {1'b0, ex};
      cobb_pkg::OP_SQB:   sq_a = {1'b0, ez};
      cobb_pkg::OP_SQR:   sq_a = rr;
      default:            sq_a = '0;
    endcase
    sq_p = 66'(sq_a) * 66'(sq_a);
  end

  always_comb begin
    case (cmd.op)
      cobb_pkg::OP_BM0: begin ma = box_rd.cs; mb = rx; end
      cobb_pkg::OP_BM1: begin ma = box_rd.sn; mb = rz; end
      cobb_pkg::OP_BM2: begin ma = box_rd.cs; mb = rz; end
      cobb_pkg::OP_BM3: begin ma = box_rd.sn; mb = rx; end
      default:          begin ma = '0; mb = '0; end
    endcase
    mp = 52'(ma) * 52'(mb);
  end

  always_comb begin
    lx   = acc_x >>> 14;
    lz   = acc_z >>> 14;
    hx_s = $signed({21'b0, box_rd.hx});
    hz_s = $signed({21'b0, box_rd.hz});
    cl_x = lx;
    if (cl_x < -hx_s) cl_x = -hx_s;
    if (cl_x > hx_s) cl_x = hx_s;
    cl_z = lz;
    if (cl_z < -hz_s) cl_z = -hz_s;
    if (cl_z > hz_s) cl_z = hz_s;
    ddx = lx - cl_x;
    ddz = lz - cl_z;
    adx = ddx[51] ? $unsigned(-ddx) : $unsigned(ddx);
    adz = ddz[51] ? $unsigned(-ddz) : $unsigned(ddz);
    dcx = {tx[34], tx} - {{4{circ_rd.cx[31]}}, circ_rd.cx};
    dcz = {tz[34], tz} - {{4{circ_rd.cz[31]}}, circ_rd.cz};
    acx = dcx[35] ? $unsigned(-dcx) : $unsigned(dcx);
    acz = dcz[35] ? $unsigned(-dcz) : $unsigned(dcz);
  end

  always_comb begin
    fin_x = px;
    fin_z = pz;
    if (bnd) begin
      if (fin_x < sx35(rmin_x)) fin_x = sx35(rmin_x);
      if (fin_x > sx35(rmax_x)) fin_x = sx35(rmax_x);
      if (fin_z < sx35(rmin_z)) fin_z = sx35(rmin_z);
      if (fin_z > sx35(rmax_z)) fin_z = sx35(rmax_z);
    end
  end

  assign stat = '{stop: (|m[41:32]) || (msq >= {1'b0, dist2}),
                  hit:  !far && (sqsum < {1'b0, rsq})};

  always_ff @(posedge clk) begin
    if (load) begin
      it <= item;
    end
    case (cmd.op)
      cobb_pkg::OP_CINIT: begin
        cx_r <= cobb_pkg::GAIN;
        cy_r <= '0;
        cz_r <= fold_z;
        cneg <= fold_neg;
      end
      cobb_pkg::OP_CSTEP: begin
        if (!cz_r[17]) begin
          cx_r <= cx_r - (cy_r >>> cmd.iter);
          cy_r <= cy_r + (cx_r >>> cmd.iter);
          cz_r <= cz_r - cobb_pkg::atan_q13(cmd.iter);
        end else begin
          cx_r <= cx_r + (cy_r >>> cmd.iter);
          cy_r <= cy_r - (cx_r >>> cmd.iter);
          cz_r <= cz_r + cobb_pkg::atan_q13(cmd.iter);
        end
      end
      cobb_pkg::OP_DISTX: begin
        dist2 <= sq_p[64:0];
        px    <= sx35(it.pos_x);
        pz    <= sx35(it.pos_z);
      end
      cobb_pkg::OP_DISTZ: dist2 <= dist2 + sq_p[64:0];
      cobb_pkg::OP_KINIT: m <= 42'(step);
      cobb_pkg::OP_KSQ:   msq <= sq_p;
      cobb_pkg::OP_KNEXT: m <= m + 42'(step);
      cobb_pkg::OP_DINIT: begin
        qx   <= mag32(it.delta_x);
        qz   <= mag32(it.delta_z);
        remx <= '0;
        remz <= '0;
      end
      cobb_pkg::OP_DSTEP: begin
        remx <= gex ? N_W_L'(r2x - {1'b0, cmd.n}) : N_W_L'(r2x);
        remz <= gez ? N_W_L'(r2z - {1'b0, cmd.n}) : N_W_L'(r2z);
        qx   <= {qx[30:0], gex};
        qz   <= {qz[30:0], gez};
      end
      cobb_pkg::OP_DFIX: begin
        sdx <= it.delta_x[31] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
        sdz <= it.delta_z[31] ? -$signed({1'b0, qz}) : $signed({1'b0, qz});
      end
      cobb_pkg::OP_TESTX: begin
        tx <= px + {{2{sdx[32]}}, sdx};
        tz <= pz;
      end
      cobb_pkg::OP_TESTZ: begin
        tx <= px;
        tz <= pz + {{2{sdz[32]}}, sdz};
      end
      cobb_pkg::OP_BREL: begin
        rx <= {tx[34], tx} - {{4{box_rd.cx[31]}}, box_rd.cx};
        rz <= {tz[34], tz} - {{4{box_rd.cz[31]}}, box_rd.cz};
        rr <= {2'b0, pr};
      end
      cobb_pkg::OP_BM0: acc_x <= mp;
      cobb_pkg::OP_BM1: acc_x <= acc_x + mp;
      cobb_pkg::OP_BM2: acc_z <= mp;
      cobb_pkg::OP_BM3: acc_z <= acc_z - mp;
      cobb_pkg::OP_BCLAMP: begin
        ex  <= adx[31:0];
        ez  <= adz[31:0];
        far <= (|adx[51:32]) || (|adz[51:32]);
      end
      cobb_pkg::OP_CREL: begin
        ex  <= acx[31:0];
        ez  <= acz[31:0];
        far <= (|acx[35:32]) || (|acz[35:32]);
        rr  <= {2'b0, pr} + {2'b0, circ_rd.r};
      end
      cobb_pkg::OP_SQA: sqacc <= sq_p;
      cobb_pkg::OP_SQB: sqsum <= {1'b0, sqacc} + {1'b0, sq_p};
      cobb_pkg::OP_SQR: rsq <= sq_p;
      cobb_pkg::OP_COMMIT: begin
        px <= tx;
        pz <= tz;
      end
      cobb_pkg::OP_FINZ: begin
        new_x <= '0;
        new_z <= '0;
      end
      cobb_pkg::OP_FINM: begin
        new_x <= sat32(fin_x);
        new_z <= sat32(fin_z);
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/cobb_ctrl.sv -----
// ----------------------------------------------------------------------------
// cobb_ctrl
// Controller: sequences table updates, the step search, the divider and
// the per-substep collider sweep, and keeps the table counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cobb_ctrl #(
  parameter int MAX_BOXES   = cobb_pkg::MAX_BOXES_DEF,
  parameter int MAX_CIRCLES = cobb_pkg::MAX_CIRCLES_DEF,
  parameter int MAX_STEPS   = cobb_pkg::MAX_STEPS_DEF,
  localparam int BAW = $clog2(MAX_BOXES > 1 ? MAX_BOXES : 2),
  localparam int CAW = $clog2(MAX_CIRCLES > 1 ? MAX_CIRCLES : 2)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [1:0]         func,
  input  cobb_pkg::dp_stat_t stat,
  output cobb_pkg::dp_cmd_t  cmd,
  output logic               box_we,
  output logic [BAW-1:0]     box_waddr,
  output logic [BAW-1:0]     box_raddr,
  output logic               circ_we,
  output logic [CAW-1:0]     circ_waddr,
  output logic [CAW-1:0]     circ_raddr,
  output logic               busy,
  output logic               done,
  output logic [1:0]         status
);

  localparam int CBW = $clog2(MAX_BOXES + 1);
  localparam int CCW = $clog2(MAX_CIRCLES + 1);
  localparam int KW  = $clog2(MAX_STEPS + 1);
  localparam int IW  = (BAW > CAW) ? BAW : CAW;

  typedef enum logic [4:0] {
    S_IDLE, S_CINIT, S_CSTEP, S_BWR, S_CWR, S_FINZ, S_DX, S_DZ, S_KINIT, S_KSQ,
    S_KCHK, S_DINIT, S_DSTEP, S_DFIX, S_TEST, S_RD, S_REL, S_BM0, S_BM1, S_BM2,
    S_BM3, S_BCL, S_SQA, S_SQB, S_SQR, S_HCHK, S_COMMIT, S_FINM
  } state_t;

  state_t         state;
  logic [CBW-1:0] box_count;
  logic [CCW-1:0] circ_count;
  logic [IW-1:0]  idx;
  logic [KW-1:0]  k, n, sub;
  logic [3:0]     iter;
  logic [4:0]     dcnt;
  logic           kind_box, axis_z, keep;
  logic           k_last;

  assign k_last = (k == KW'(MAX_STEPS));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      box_count  <= '0;
      circ_count <= '0;
      idx        <= '0;
      k          <= '0;
      n          <= '0;
      sub        <= '0;
      iter       <= '0;
      dcnt       <= '0;
      kind_box   <= 1'b0;
      axis_z     <= 1'b0;
      keep       <= 1'b0;
      done       <= 1'b0;
      status     <= cobb_pkg::ST_OK;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: if (accept) begin
          status <= cobb_pkg::ST_OK;
          case (func)
            cobb_pkg::FUNC_CLEAR: begin
              box_count  <= '0;
              circ_count <= '0;
              state      <= S_FINZ;
            end
            cobb_pkg::FUNC_BOX: begin
              if (box_count >= CBW'(MAX_BOXES)) begin
                status <= cobb_pkg::ST_FULL;
                state  <= S_FINZ;
              end else begin
                state <= S_CINIT;
              end
            end
            cobb_pkg::FUNC_CIRCLE: begin
              if (circ_count >= CCW'(MAX_CIRCLES)) begin
                status <= cobb_pkg::ST_FULL;
                state  <= S_FINZ;
              end else begin
                state <= S_CWR;
              end
            end
            default: state <= S_DX;
          endcase
        end
        S_CINIT: begin
          iter  <= '0;
          state <= S_CSTEP;
        end
        S_CSTEP: begin
          iter <= iter + 4'd1;
          if (iter == 4'(cobb_pkg::CORDIC_ITERS - 1)) state <= S_BWR;
        end
        S_BWR: begin
          box_count <= box_count + CBW'(1);
          state     <= S_FINZ;
        end
        S_CWR: begin
          circ_count <= circ_count + CCW'(1);
          state      <= S_FINZ;
        end
        S_FINZ, S_FINM: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_DX: state <= S_DZ;
        S_DZ: state <= S_KINIT;
        S_KINIT: begin
          k     <= KW'(1);
          state <= S_KSQ;
        end
        S_KSQ: state <= S_KCHK;
        S_KCHK: begin
          if (stat.stop) begin
            n     <= k;
            state <= S_DINIT;
          end else if (k_last) begin
            n      <= k;
            status <= cobb_pkg::ST_SAT;
            state  <= S_DINIT;
          end else begin
            k     <= k + KW'(1);
            state <= S_KSQ;
          end
        end
        S_DINIT: begin
          dcnt  <= '0;
          state <= S_DSTEP;
        end
        S_DSTEP: begin
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'd31) state <= S_DFIX;
        end
        S_DFIX: begin
          sub    <= '0;
          axis_z <= 1'b0;
          state  <= S_TEST;
        end
        S_TEST: begin
          idx  <= '0;
          keep <= 1'b1;
          if (box_count != '0) begin
            kind_box <= 1'b1;
            state    <= S_RD;
          end else if (circ_count != '0) begin
            kind_box <= 1'b0;
            state    <= S_RD;
          end else begin
            state <= S_COMMIT;
          end
        end
        S_RD:  state <= S_REL;
        S_REL: state <= kind_box ? S_BM0 : S_SQA;
        S_BM0: state <= S_BM1;
        S_BM1: state <= S_BM2;
        S_BM2: state <= S_BM3;
        S_BM3: state <= S_BCL;
        S_BCL: state <= S_SQA;
        S_SQA: state <= S_SQB;
        S_SQB: state <= S_SQR;
        S_SQR: state <= S_HCHK;
        S_HCHK: begin
          if (stat.hit) begin
            keep  <= 1'b0;
            state <= S_COMMIT;
          end else if (kind_box && ((CBW'(idx) + CBW'(1)) < box_count)) begin
            idx   <= idx + IW'(1);
            state <= S_RD;
          end else if (kind_box && (circ_count != '0)) begin
            kind_box <= 1'b0;
            idx      <= '0;
            state    <= S_RD;
          end else if (!kind_box && ((CCW'(idx) + CCW'(1)) < circ_count)) begin
            idx   <= idx + IW'(1);
            state <= S_RD;
          end else begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (!axis_z) begin
            axis_z <= 1'b1;
            state  <= S_TEST;
          end else begin
            axis_z <= 1'b0;
            if ((sub + KW'(1)) == n) begin
              state <= S_FINM;
            end else begin
              sub   <= sub + KW'(1);
              state <= S_TEST;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.iter = iter;
    cmd.n    = cobb_pkg::N_W'(n);
    case (state)
      S_CINIT:  cmd.op = cobb_pkg::OP_CINIT;
      S_CSTEP:  cmd.op = cobb_pkg::OP_CSTEP;
      S_DX:     cmd.op = cobb_pkg::OP_DISTX;
      S_DZ:     cmd.op = cobb_pkg::OP_DISTZ;
      S_KINIT:  cmd.op = cobb_pkg::OP_KINIT;
      S_KSQ:    cmd.op = cobb_pkg::OP_KSQ;
      S_KCHK:   cmd.op = (!stat.stop && !k_last) ? cobb_pkg::OP_KNEXT : cobb_pkg::OP_NONE;
      S_DINIT:  cmd.op = cobb_pkg::OP_DINIT;
      S_DSTEP:  cmd.op = cobb_pkg::OP_DSTEP;
      S_DFIX:   cmd.op = cobb_pkg::OP_DFIX;
      S_TEST:   cmd.op = axis_z ? cobb_pkg::OP_TESTZ : cobb_pkg::OP_TESTX;
      S_REL:    cmd.op = kind_box ? cobb_pkg::OP_BREL : cobb_pkg::OP_CREL;
      S_BM0:    cmd.op = cobb_pkg::OP_BM0;
      S_BM1:    cmd.op = cobb_pkg::OP_BM1;
      S_BM2:    cmd.op = cobb_pkg::OP_BM2;
      S_BM3:    cmd.op = cobb_pkg::OP_BM3;
      S_BCL:    cmd.op = cobb_pkg::OP_BCLAMP;
      S_SQA:    cmd.op = cobb_pkg::OP_SQA;
      S_SQB:    cmd.op = cobb_pkg::OP_SQB;
      S_SQR:    cmd.op = cobb_pkg::OP_SQR;
      S_COMMIT: cmd.op = keep ? cobb_pkg::OP_COMMIT : cobb_pkg::OP_NONE;
      S_FINZ:   cmd.op = cobb_pkg::OP_FINZ;
      S_FINM:   cmd.op = cobb_pkg::OP_FINM;
      default:  cmd.op = cobb_pkg::OP_NONE;
    endcase
  end

  assign box_we     = (state == S_BWR);
  assign circ_we    = (state == S_CWR);
  assign box_waddr  = box_count[BAW-1:0];
  assign circ_waddr = circ_count[CAW-1:0];
  assign box_raddr  = idx[BAW-1:0];
  assign circ_raddr = idx[CAW-1:0];
  assign busy       = (state != S_IDLE);

endmodule

// ----- rtl/circle_obb_slide_collision.sv -----
// ----------------------------------------------------------------------------
// circle_obb_slide_collision
// Circle versus oriented box collision with axis sliding on the XZ plane.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its single
// result appears for one cycle with done, and the receiver cannot stall it.
// A clear and an add-circle update the table counts and end with done; an
// add-box first runs the 14 CORDIC iterations. A move runs the distance,
// the step search and the divider, then for each of the N substeps tests
// the X and then the Z axis with a collider sweep over the boxes and then
// the circles up to the first hit; the sweep's length is set by the single
// shared squaring multiplier and the registered table read.
`timescale 1ns / 1ps

module circle_obb_slide_collision #(
  parameter int MAX_BOXES   = cobb_pkg::MAX_BOXES_DEF,
  parameter int MAX_CIRCLES = cobb_pkg::MAX_CIRCLES_DEF,
  parameter int MAX_STEPS   = cobb_pkg::MAX_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  cobb_pkg::item_t   item,
  output logic              done,
  output cobb_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  localparam int BAW = $clog2(MAX_BOXES > 1 ? MAX_BOXES : 2);
  localparam int CAW = $clog2(MAX_CIRCLES > 1 ? MAX_CIRCLES : 2);

  logic               accept;
  cobb_pkg::dp_cmd_t  cmd;
  cobb_pkg::dp_stat_t stat;
  cobb_pkg::box_t     box_wr, box_rd;
  cobb_pkg::circ_t    circ_wr, circ_rd;
  logic               box_we, circ_we;
  logic [BAW-1:0]     box_waddr, box_raddr;
  logic [CAW-1:0]     circ_waddr, circ_raddr;
  logic [1:0]         status;
  logic signed [31:0] new_x, new_z;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign result    = '{new_x: new_x, new_z: new_z, status: status};

  cobb_ctrl #(
    .MAX_BOXES  (MAX_BOXES),
    .MAX_CIRCLES(MAX_CIRCLES),
    .MAX_STEPS  (MAX_STEPS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .func      (item.func),
    .stat      (stat),
    .cmd       (cmd),
    .box_we    (box_we),
    .box_waddr (box_waddr),
    .box_raddr (box_raddr),
    .circ_we   (circ_we),
    .circ_waddr(circ_waddr),
    .circ_raddr(circ_raddr),
    .busy      (busy),
    .done      (done),
    .status    (status)
  );

  cobb_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .item     (item),
    .cfg_we   (cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .box_rd   (box_rd),
    .circ_rd  (circ_rd),
    .box_wr   (box_wr),
    .circ_wr  (circ_wr),
    .stat     (stat),
    .new_x    (new_x),
    .new_z    (new_z)
  );

  cobb_ram #(
    .WIDTH($bits(cobb_pkg::box_t)),
    .DEPTH(MAX_BOXES)
  ) u_box_ram (
    .clk  (clk),
    .we   (box_we),
    .waddr(box_waddr),
    .wdata(box_wr),
    .raddr(box_raddr),
    .rdata(box_rd)
  );

  cobb_ram #(
    .WIDTH($bits(cobb_pkg::circ_t)),
    .DEPTH(MAX_CIRCLES)
  ) u_circ_ram (
    .clk  (clk),
    .we   (circ_we),
    .waddr(circ_waddr),
    .wdata(circ_wr),
    .raddr(circ_raddr),
    .rdata(circ_rd)
  );

`include "circle_obb_slide_collision_assert.svh"

  `COBB_ASSERT_IMP(a_done_after_busy, done, $past(busy))
  `COBB_ASSERT_IMP(a_done_idle, done, !busy)
  `COBB_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `COBB_ASSERT_IMP(a_full_zero, done && status == cobb_pkg::ST_FULL, !(|{new_x, new_z}))

endmodule
